/* rtl/fuzzy_membership_unit_assert.svh */
// Assertion macros for the checker file of the membership unit.
`ifndef FUZZY_MEMBERSHIP_UNIT_ASSERT_SVH
`define FUZZY_MEMBERSHIP_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define FMU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define FMU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fmu_pkg.sv */
package fmu_pkg;

  // Default widths.
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 15;
  localparam int PT_BITS         = 16;

  // Inverse quadratic fixed point: k*d^2 has 24 fraction bits, D saturates at 2^56.
  localparam int IQ_FRAC      = 24;
  localparam int IQ_LIMIT_EXP = 56;
  localparam int DEN_BITS     = IQ_LIMIT_EXP + 1;

  // Shape codes.
  localparam logic [2:0] SHAPE_RISE  = 3'd0;
  localparam logic [2:0] SHAPE_FALL  = 3'd1;
  localparam logic [2:0] SHAPE_TRI   = 3'd2;
  localparam logic [2:0] SHAPE_TRAP  = 3'd3;
  localparam logic [2:0] SHAPE_SCURV = 3'd4;
  localparam logic [2:0] SHAPE_BELL  = 3'd5;
  localparam logic [2:0] SHAPE_INVQ  = 3'd6;

  // Hedge codes.
  localparam logic [1:0] HEDGE_NONE     = 2'd0;
  localparam logic [1:0] HEDGE_SQRT     = 2'd1;
  localparam logic [1:0] HEDGE_SQUARE   = 2'd2;
  localparam logic [1:0] HEDGE_CONTRAST = 2'd3;

  // Register indexes.
  localparam logic [2:0] REG_SHAPE = 3'd0;
  localparam logic [2:0] REG_HEDGE = 3'd1;
  localparam logic [2:0] REG_PA    = 3'd2;
  localparam logic [2:0] REG_PB    = 3'd3;
  localparam logic [2:0] REG_PC    = 3'd4;
  localparam logic [2:0] REG_PD    = 3'd5;
  localparam logic [2:0] REG_STEEP = 3'd6;

  // Configuration seen by the front end.
  typedef struct packed {
    logic [2:0]         shape_mode;
    logic [1:0]         hedge_mode;
    logic signed [15:0] point_a;
    logic signed [15:0] point_b;
    logic signed [15:0] point_c;
    logic signed [15:0] point_d;
    logic [15:0]        steepness;
  } cfg_t;

  // Per-item control that rides down the pipeline with the data.
  typedef struct packed {
    logic       bad;    // breakpoints out of order, or bell b below 2
    logic [1:0] hedge;  // hedge to apply at the end
    logic       ovr;    // ratio replaced by a constant
    logic       one;    // the constant is one, else zero
    logic       sq;     // apply the saturated twice-square
    logic       inv;    // take one minus the value
    logic       iq;     // inverse quadratic division
  } side_t;

endpackage

/* rtl/fmu_front.sv */
module fmu_front #(
  parameter int SAMPLE_BITS = fmu_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = fmu_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  fmu_pkg::cfg_t                 cfg_i,
  output logic                          valid_o,
  output fmu_pkg::side_t                side_o,
  output logic [fmu_pkg::DEN_BITS-1:0]  rem_o,
  output logic [FRAC_BITS:0]            low_o,
  output logic [fmu_pkg::DEN_BITS-1:0]  den_o
);

  localparam int W  = ((SAMPLE_BITS > fmu_pkg::PT_BITS) ? SAMPLE_BITS : fmu_pkg::PT_BITS) + 3;
  localparam int DW = fmu_pkg::DEN_BITS;
  localparam int KW0 = 2 * W + 16;
  localparam int KW = (KW0 > DW + 1) ? KW0 : DW + 1;
  localparam logic [KW-1:0] IQ_LIMIT = KW'(1) << fmu_pkg::IQ_LIMIT_EXP;
  localparam logic [KW-1:0] IQ_BASE  = KW'(1) << fmu_pkg::IQ_FRAC;
  localparam logic [DW-1:0] IQ_REM   = DW'(1) << (fmu_pkg::IQ_FRAC - 1);

  fmu_pkg::side_t        side_d;
  logic [W-1:0]          num_d;
  logic [W-1:0]          den_d;
  logic [W-1:0]          ad_d;

  // Pick the ramp operands and the constant cases for one sample.
  always_comb begin
    logic signed [W-1:0] x, a, b, c, d, h, lo, rn, rd, dxa;
    logic                use_r;
    x      = W'(sample_i);
    a      = W'(cfg_i.point_a);
    b      = W'(cfg_i.point_b);
    c      = W'(cfg_i.point_c);
    d      = W'(cfg_i.point_d);
    h      = b >>> 1;
    lo     = a - b;
    rn     = '0;
    rd     = W'(1);
    use_r  = 1'b0;
    side_d = '0;
    side_d.hedge = cfg_i.hedge_mode;
    side_d.ovr   = 1'b1;
    unique case (cfg_i.shape_mode) inside
      fmu_pkg::SHAPE_RISE, fmu_pkg::SHAPE_FALL: begin
        if (!(a < b)) begin
          side_d.bad = 1'b1;
        end else begin
          use_r      = 1'b1;
          rn         = x - a;
          rd         = b - a;
          side_d.inv = (cfg_i.shape_mode == fmu_pkg::SHAPE_FALL);
        end
      end
      fmu_pkg::SHAPE_TRI: begin
        if (!(a < b && b < c)) begin
          side_d.bad = 1'b1;
        end else if (x < a || x >= c) begin
          side_d.one = 1'b0;
        end else if (x < b) begin
          use_r = 1'b1;
          rn    = x - a;
          rd    = b - a;
        end else begin
          use_r = 1'b1;
          rn    = c - x;
          rd    = c - b;
        end
      end
      fmu_pkg::SHAPE_TRAP: begin
        if (!(a < b && b < c && c < d)) begin
          side_d.bad = 1'b1;
        end else if (x < a || x >= d) begin
          side_d.one = 1'b0;
        end else if (x >= b && x < c) begin
          side_d.one = 1'b1;
        end else if (x < b) begin
          use_r = 1'b1;
          rn    = x - a;
          rd    = b - a;
        end else begin
          use_r = 1'b1;
          rn    = d - x;
          rd    = d - c;
        end
      end
      fmu_pkg::SHAPE_SCURV: begin
        if (!(a < b && b < c)) begin
          side_d.bad = 1'b1;
        end else if (x < a) begin
          side_d.one = 1'b0;
        end else if (x >= c) begin
          side_d.one = 1'b1;
        end else if (x < b) begin
          use_r     = 1'b1;
          rn        = x - a;
          rd        = c - a;
          side_d.sq = 1'b1;
        end else begin
          use_r      = 1'b1;
          rn         = c - x;
          rd         = c - a;
          side_d.sq  = 1'b1;
          side_d.inv = 1'b1;
        end
      end
      fmu_pkg::SHAPE_BELL: begin
        if (b < W'(2)) begin
          side_d.bad = 1'b1;
        end else if (x < a) begin
          // Left half: rising S-curve from a-b to a.
          if (x < lo) begin
            side_d.one = 1'b0;
          end else if (x < a - h) begin
            use_r     = 1'b1;
            rn        = x - lo;
            rd        = b;
            side_d.sq = 1'b1;
          end else begin
            use_r      = 1'b1;
            rn         = a - x;
            rd         = b;
            side_d.sq  = 1'b1;
            side_d.inv = 1'b1;
          end
        end else begin
          // Right half: one minus the S-curve from a to a+b.
          if (x >= a + b) begin
            side_d.one = 1'b0;
          end else if (x < a + h) begin
            use_r      = 1'b1;
            rn         = x - a;
            rd         = b;
            side_d.sq  = 1'b1;
            side_d.inv = 1'b1;
          end else begin
            use_r     = 1'b1;
            rn        = a + b - x;
            rd        = b;
            side_d.sq = 1'b1;
          end
        end
      end
      fmu_pkg::SHAPE_INVQ: begin
        side_d.ovr = 1'b0;
        side_d.iq  = 1'b1;
      end
      default: begin
        side_d.one = 1'b0;
      end
    endcase
    // Ramp ratio end points become constants; only the open interior divides.
    if (use_r) begin
      if (rd <= 0) begin
        side_d.one = 1'b1;
      end else if (rn <= 0) begin
        side_d.one = 1'b0;
      end else if (rn >= rd) begin
        side_d.one = 1'b1;
      end else begin
        side_d.ovr = 1'b0;
      end
    end
    num_d = rn;
    den_d = rd;
    dxa   = x - a;
    ad_d  = (dxa < 0) ? -dxa : dxa;
  end

  logic                 v0_q, v1_q, v2_q;
  fmu_pkg::side_t       side0_q, side1_q, side2_q;
  logic [W-1:0]         num0_q, num1_q, num2_q;
  logic [W-1:0]         den0_q, den1_q, den2_q;
  logic [W-1:0]         ad0_q;
  logic [2*W-1:0]       d2_q;
  logic [KW0-1:0]       kd2_q;

  // Valid bits of the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v0_q    <= valid_i;
      v1_q    <= v0_q;
      v2_q    <= v1_q;
      valid_o <= v2_q;
    end
  end

  // Square the distance, then scale it by the gain, one product per stage.
  always_ff @(posedge clk_i) begin
    side0_q <= side_d;
    num0_q  <= num_d;
    den0_q  <= den_d;
    ad0_q   <= ad_d;
    side1_q <= side0_q;
    num1_q  <= num0_q;
    den1_q  <= den0_q;
    d2_q    <= ad0_q * ad0_q;
    side2_q <= side1_q;
    num2_q  <= num1_q;
    den2_q  <= den1_q;
    kd2_q   <= KW0'(cfg_i.steepness) * KW0'(d2_q);
  end

  // Load the divider: ramps divide num*2^F, inverse quadratic divides 2^(F+24).
  always_ff @(posedge clk_i) begin
    logic [KW-1:0] kd2_w;
    logic [KW-1:0] dden;
    kd2_w  = KW'(kd2_q);
    dden   = (kd2_w > IQ_LIMIT) ? IQ_LIMIT : IQ_BASE + kd2_w;
    side_o <= side2_q;
    if (side2_q.iq) begin
      rem_o <= IQ_REM;
      low_o <= '0;
      den_o <= DW'(dden);
    end else begin
      rem_o <= DW'(num2_q >> 1);
      low_o <= {num2_q[0], {FRAC_BITS{1'b0}}};
      den_o <= DW'(den2_q);
    end
  end

endmodule

/* rtl/fmu_div_cell.sv */
module fmu_div_cell #(
  parameter int DW = fmu_pkg::DEN_BITS,
  parameter int QW = fmu_pkg::FRAC_BITS_DEF + 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  fmu_pkg::side_t side_i,
  input  logic [DW-1:0]  rem_i,
  input  logic [QW-1:0]  low_i,
  input  logic [DW-1:0]  den_i,
  input  logic [QW-1:0]  quo_i,
  output logic           valid_o,
  output fmu_pkg::side_t side_o,
  output logic [DW-1:0]  rem_o,
  output logic [QW-1:0]  low_o,
  output logic [DW-1:0]  den_o,
  output logic [QW-1:0]  quo_o
);

  logic [DW:0] trial;
  logic        ge;

  // One restoring quotient bit: bring down the next dividend bit and try a subtract.
  assign trial = {rem_i, low_i[QW-1]};
  assign ge    = (trial >= {1'b0, den_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_i;
    rem_o  <= ge ? DW'(trial - {1'b0, den_i}) : DW'(trial);
    low_o  <= low_i << 1;
    den_o  <= den_i;
    quo_o  <= {quo_i[QW-2:0], ge};
  end

endmodule

/* rtl/fmu_sqrt_cell.sv */
module fmu_sqrt_cell #(
  parameter int QW = fmu_pkg::FRAC_BITS_DEF + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  fmu_pkg::side_t  side_i,
  input  logic [QW-1:0]   m_i,
  input  logic [2*QW-1:0] rad_i,
  input  logic [QW+1:0]   rem_i,
  input  logic [QW-1:0]   root_i,
  output logic            valid_o,
  output fmu_pkg::side_t  side_o,
  output logic [QW-1:0]   m_o,
  output logic [2*QW-1:0] rad_o,
  output logic [QW+1:0]   rem_o,
  output logic [QW-1:0]   root_o
);

  logic [QW+3:0] trial;
  logic [QW+3:0] sub;
  logic          ge;

  // One root digit: bring down two radicand bits and try subtracting 4y+1.
  assign trial = {rem_i, rad_i[2*QW-1 -: 2]};
  assign sub   = (QW+4)'({root_i, 2'b01});
  assign ge    = (trial >= sub);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_i;
    m_o    <= m_i;
    rad_o  <= rad_i << 2;
    rem_o  <= ge ? (QW+2)'(trial - sub) : (QW+2)'(trial);
    root_o <= {root_i[QW-2:0], ge};
  end

endmodule

/* rtl/fuzzy_membership_unit.sv */
// Fuzzy membership unit. Each sample (signed Q8.8) accepted with start yields exactly one
// degree in Q1.FRAC_BITS, shown on degree_o and bad_setting_o for one cycle while done_o is
// high. busy is never raised, so a sample may be given on every cycle; results leave in
// order and cannot be stalled, so the receiver must take done_o beats as they come. The
// pipeline holds two chains of FRAC_BITS+1 cells, the divider that forms the ramp ratio or
// the inverse quadratic, and the square-root chain of the dilation hedge, plus ten product
// and select stages. The user must write configuration through the APB port only while no
// sample is in flight; the block itself does not enforce this.
module fuzzy_membership_unit #(
  parameter int SAMPLE_BITS = fmu_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = fmu_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          done_o,
  output logic [FRAC_BITS:0]            degree_o,
  output logic                          bad_setting_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int QW = FRAC_BITS + 1;
  localparam int DW = fmu_pkg::DEN_BITS;
  localparam logic [QW-1:0] ONE  = QW'(1) << FRAC_BITS;
  localparam logic [QW-1:0] HALF = ONE >> 1;

  fmu_pkg::cfg_t cfg_q;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shape_mode <= fmu_pkg::SHAPE_RISE;
      cfg_q.hedge_mode <= fmu_pkg::HEDGE_NONE;
      cfg_q.point_a    <= 16'sd0;
      cfg_q.point_b    <= 16'sd256;
      cfg_q.point_c    <= 16'sd512;
      cfg_q.point_d    <= 16'sd768;
      cfg_q.steepness  <= 16'd256;
    end else if (wr_en) begin
      unique case (reg_idx)
        fmu_pkg::REG_SHAPE: cfg_q.shape_mode <= pwdata[2:0];
        fmu_pkg::REG_HEDGE: cfg_q.hedge_mode <= pwdata[1:0];
        fmu_pkg::REG_PA:    cfg_q.point_a    <= pwdata[15:0];
        fmu_pkg::REG_PB:    cfg_q.point_b    <= pwdata[15:0];
        fmu_pkg::REG_PC:    cfg_q.point_c    <= pwdata[15:0];
        fmu_pkg::REG_PD:    cfg_q.point_d    <= pwdata[15:0];
        fmu_pkg::REG_STEEP: cfg_q.steepness  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back, signed breakpoints sign-extended.
  always_comb begin
    unique case (reg_idx)
      fmu_pkg::REG_SHAPE: prdata = {29'd0, cfg_q.shape_mode};
      fmu_pkg::REG_HEDGE: prdata = {30'd0, cfg_q.hedge_mode};
      fmu_pkg::REG_PA:    prdata = 32'(cfg_q.point_a);
      fmu_pkg::REG_PB:    prdata = 32'(cfg_q.point_b);
      fmu_pkg::REG_PC:    prdata = 32'(cfg_q.point_c);
      fmu_pkg::REG_PD:    prdata = 32'(cfg_q.point_d);
      fmu_pkg::REG_STEEP: prdata = {16'd0, cfg_q.steepness};
      default:            prdata = '0;
    endcase
  end

  // Front end: shape decode and the inverse quadratic denominator.
  logic           dv   [QW+1];
  fmu_pkg::side_t dside[QW+1];
  logic [DW-1:0]  drem [QW+1];
  logic [QW-1:0]  dlow [QW+1];
  logic [DW-1:0]  dden [QW+1];
  logic [QW-1:0]  dquo [QW+1];

  fmu_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .sample_i(sample_i),
    .cfg_i   (cfg_q),
    .valid_o (dv[0]),
    .side_o  (dside[0]),
    .rem_o   (drem[0]),
    .low_o   (dlow[0]),
    .den_o   (dden[0])
  );
  assign dquo[0] = '0;

  // Divider chain: one quotient bit per cell.
  for (genvar i = 0; i < QW; i++) begin : g_div
    fmu_div_cell #(.DW(DW), .QW(QW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(dv[i]),
      .side_i (dside[i]),
      .rem_i  (drem[i]),
      .low_i  (dlow[i]),
      .den_i  (dden[i]),
      .quo_i  (dquo[i]),
      .valid_o(dv[i+1]),
      .side_o (dside[i+1]),
      .rem_o  (drem[i+1]),
      .low_o  (dlow[i+1]),
      .den_o  (dden[i+1]),
      .quo_o  (dquo[i+1])
    );
  end

  // Shape finish: constant override, saturated twice-square, complement.
  logic             v1_q, v2_q, v3_q;
  fmu_pkg::side_t   side1_q, side2_q, side3_q;
  logic [QW-1:0]    r1_q, r2_q, m3_q;
  logic [2*QW-1:0]  p2_q;
  logic [QW-1:0]    m3_d;

  always_comb begin
    logic [2*QW-1:0] tw;
    logic [QW-1:0]   val;
    tw   = p2_q >> (FRAC_BITS - 1);
    val  = side2_q.sq ? ((tw > (2*QW)'(ONE)) ? ONE : QW'(tw)) : r2_q;
    m3_d = side2_q.inv ? ONE - val : val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= dv[QW];
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side1_q <= dside[QW];
    r1_q    <= dside[QW].ovr ? (dside[QW].one ? ONE : '0) : dquo[QW];
    side2_q <= side1_q;
    r2_q    <= r1_q;
    p2_q    <= (2*QW)'(r1_q) * (2*QW)'(r1_q);
    side3_q <= side2_q;
    m3_q    <= m3_d;
  end

  // Square-root chain over m*2^F: one root digit per cell.
  logic            sv   [QW+1];
  fmu_pkg::side_t  sside[QW+1];
  logic [QW-1:0]   sm   [QW+1];
  logic [2*QW-1:0] srad [QW+1];
  logic [QW+1:0]   srem [QW+1];
  logic [QW-1:0]   sroot[QW+1];

  assign sv[0]    = v3_q;
  assign sside[0] = side3_q;
  assign sm[0]    = m3_q;
  assign srad[0]  = {1'b0, m3_q, {FRAC_BITS{1'b0}}};
  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_sqrt
    fmu_sqrt_cell #(.QW(QW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(sv[i]),
      .side_i (sside[i]),
      .m_i    (sm[i]),
      .rad_i  (srad[i]),
      .rem_i  (srem[i]),
      .root_i (sroot[i]),
      .valid_o(sv[i+1]),
      .side_o (sside[i+1]),
      .m_o    (sm[i+1]),
      .rad_o  (srad[i+1]),
      .rem_o  (srem[i+1]),
      .root_o (sroot[i+1])
    );
  end

  // Hedge: fold the upper half for contrast, square, then select.
  logic            hv1_q, hv2_q;
  fmu_pkg::side_t  hside1_q, hside2_q;
  logic [QW-1:0]   hm1_q, hm2_q, hroot1_q, hroot2_q, hop1_q;
  logic            hhi1_q, hhi2_q;
  logic [2*QW-1:0] hp2_q;
  logic            hhi_d;
  logic [QW-1:0]   degree_d;

  assign hhi_d = (sside[QW].hedge == fmu_pkg::HEDGE_CONTRAST) && (sm[QW] > HALF);

  always_comb begin
    logic [2*QW-1:0] tw;
    logic [QW-1:0]   s;
    tw = hp2_q >> (FRAC_BITS - 1);
    s  = (tw > (2*QW)'(ONE)) ? ONE : QW'(tw);
    case (hside2_q.hedge)
      fmu_pkg::HEDGE_SQRT:     degree_d = hroot2_q;
      fmu_pkg::HEDGE_SQUARE:   degree_d = QW'(hp2_q >> FRAC_BITS);
      fmu_pkg::HEDGE_CONTRAST: degree_d = hhi2_q ? ONE - s : s;
      default:                 degree_d = hm2_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv1_q  <= 1'b0;
      hv2_q  <= 1'b0;
      done_o <= 1'b0;
    end else begin
      hv1_q  <= sv[QW];
      hv2_q  <= hv1_q;
      done_o <= hv2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hside1_q      <= sside[QW];
    hm1_q         <= sm[QW];
    hroot1_q      <= sroot[QW];
    hhi1_q        <= hhi_d;
    hop1_q        <= hhi_d ? ONE - sm[QW] : sm[QW];
    hside2_q      <= hside1_q;
    hm2_q         <= hm1_q;
    hroot2_q      <= hroot1_q;
    hhi2_q        <= hhi1_q;
    hp2_q         <= (2*QW)'(hop1_q) * (2*QW)'(hop1_q);
    degree_o      <= degree_d;
    bad_setting_o <= hside2_q.bad;
  end

endmodule

/* rtl/fmu_checker.sv */
`include "fuzzy_membership_unit_assert.svh"

module fmu_checker #(
  parameter int FracBits = fmu_pkg::FRAC_BITS_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic [FracBits:0] degree_o,
  input logic              bad_setting_o
);

  localparam int Lat = 2 * FracBits + 12;
  localparam logic [FracBits:0] One = (FracBits+1)'(1) << FracBits;

  // A degree never exceeds one.
  `FMU_ASSERT_NOW(a_degree_range, done_o, degree_o <= One, "degree above one")
  // A bad setting forces degree zero.
  `FMU_ASSERT_NOW(a_bad_zero, done_o && bad_setting_o, degree_o == '0, "bad setting with degree")
  // Every accepted sample gives a result beat after the fixed latency.
  `FMU_ASSERT_NOW(a_result_follows, start && !busy, ##Lat done_o, "result beat missing")
  // No result beat appears without a sample accepted that long before.
  `FMU_ASSERT_NOW(a_no_spurious, done_o, $past(start && !busy, Lat), "result beat without sample")

endmodule

bind fuzzy_membership_unit fmu_checker #(.FracBits(FRAC_BITS)) u_fmu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .degree_o     (degree_o),
  .bad_setting_o(bad_setting_o)
);
